@@ sv/lsf_pkg.sv @@
// lsf_pkg: shared types and constants of the least-squares line fit
// depends on nothing; used by the controller, the datapath and the top level
package lsf_pkg;

    // fixed field widths
    localparam int XY_W    = 16;
    localparam int SUM_W   = 32;
    localparam int SXX_W   = 47;
    localparam int SXY_W   = 48;
    localparam int MIN_W   = 62;
    localparam int DEN_W   = 63;
    localparam int RES_W   = 32;
    localparam int STAT_W  = 2;

    // shared multiplier: operand A split in two halves, operand B whole
    localparam int A_W     = 48;
    localparam int HALF_W  = 24;
    localparam int B_W     = 32;
    localparam int PROD_W  = HALF_W + B_W;
    localparam int ACC_W   = 80;

    // bit-serial divider
    localparam int DIV_W   = 88;
    localparam int QUO_W   = 33;
    localparam int DCNT_W  = 7;

    // product terms of the fit, two per quantity
    localparam int TERM_W  = 3;
    localparam logic [TERM_W-1:0] TERM_N_SXX   = 3'd0;
    localparam logic [TERM_W-1:0] TERM_SX_SX   = 3'd1;
    localparam logic [TERM_W-1:0] TERM_N_SXY   = 3'd2;
    localparam logic [TERM_W-1:0] TERM_SX_SY   = 3'd3;
    localparam logic [TERM_W-1:0] TERM_SXX_SY  = 3'd4;
    localparam logic [TERM_W-1:0] TERM_SX_SXY  = 3'd5;
    localparam logic [TERM_W-1:0] TERM_DONE    = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW       = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEGEN     = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_MANY  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic                accum;
        logic                clr_run;
        logic                clr_acc;
        logic                mul;
        logic [TERM_W-1:0]   term;
        logic                half;
        logic                acc_add;
        logic                save_d;
        logic                div_load;
        logic                div_step;
        logic                div_fin;
        logic                sel_icpt;
        logic                emit;
        logic [STAT_W-1:0]   emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic overflowed;
        logic few_points;
        logic degenerate;
        logic out_busy;
    } t_stat;

endpackage

@@ sv/lsf_datapath.sv @@
// lsf_datapath: point sums, shared multiplier and accumulator, divider, output register
// depends on lsf_pkg; driven by lsf_controller commands
module lsf_datapath #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsf_pkg::t_cmd                 i_cmd,
    output lsf_pkg::t_stat                o_stat,
    input  logic signed [lsf_pkg::XY_W-1:0] i_x_value,
    input  logic signed [lsf_pkg::XY_W-1:0] i_y_value,
    input  logic                          i_cfg_we,
    input  logic [lsf_pkg::MIN_W-1:0]     i_cfg_data,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [lsf_pkg::STAT_W-1:0]    o_status,
    output logic signed [lsf_pkg::RES_W-1:0] o_slope,
    output logic signed [lsf_pkg::RES_W-1:0] o_intercept
);
    import lsf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic [SXX_W-1:0]        r_sxx;
    logic signed [SXY_W-1:0] r_sxy;
    logic [MIN_W-1:0]        r_min;
    logic [DEN_W-1:0]        r_d;
    logic signed [ACC_W-1:0] r_acc;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_prod_neg, r_prod_hi;
    logic [DIV_W-1:0]        r_dvd;
    logic [DEN_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_q;
    logic                    r_qovf, r_dneg;
    logic [RES_W-1:0]        r_slope, r_icpt;
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic [RES_W-1:0]        r_out_slope, r_out_icpt;

    // per point products
    logic signed [2*XY_W-1:0] xx, xy;
    assign xx = i_x_value * i_x_value;
    assign xy = i_x_value * i_y_value;

    // run accumulation and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
            r_min   <= MIN_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            if (i_cmd.clr_run) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxx   <= '0;
                r_sxy   <= '0;
            end else if (i_cmd.accum && !r_ovf) begin
                if (r_count == CNT_MAX) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_sx    <= r_sx + SUM_W'(i_x_value);
                    r_sy    <= r_sy + SUM_W'(i_y_value);
                    r_sxx   <= r_sxx + SXX_W'(unsigned'(xx));
                    r_sxy   <= r_sxy + SXY_W'(xy);
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // operand selection for the product terms
    logic signed [A_W-1:0] a_val;
    logic signed [B_W:0]   b_val;
    logic [A_W-1:0]        a_mag;
    logic [B_W:0]          b_mag;
    logic [HALF_W-1:0]     a_part;
    always_comb begin
        case (i_cmd.term)
            TERM_N_SXX:  begin a_val = A_W'($signed({1'b0, r_sxx})); b_val = (B_W+1)'(r_count); end
            TERM_SX_SX:  begin a_val = A_W'(r_sx);  b_val = (B_W+1)'(r_sx); end
            TERM_N_SXY:  begin a_val = r_sxy;       b_val = (B_W+1)'(r_count); end
            TERM_SX_SY:  begin a_val = A_W'(r_sy);  b_val = (B_W+1)'(r_sx); end
            TERM_SXX_SY: begin a_val = A_W'($signed({1'b0, r_sxx})); b_val = (B_W+1)'(r_sy); end
            TERM_SX_SXY: begin a_val = r_sxy;       b_val = (B_W+1)'(r_sx); end
            default:     begin a_val = '0;          b_val = '0; end
        endcase
        a_mag  = a_val[A_W-1] ? A_W'(-a_val) : A_W'(a_val);
        b_mag  = b_val[B_W] ? (B_W+1)'(-b_val) : (B_W+1)'(b_val);
        a_part = i_cmd.half ? a_mag[A_W-1:HALF_W] : a_mag[HALF_W-1:0];
    end

    // accumulate step and divider signals
    logic [ACC_W-1:0]        prod_ext;
    logic [ACC_W-1:0]        acc_mag;
    logic [DEN_W:0]          rem_sh;
    logic                    ge;
    logic [DEN_W:0]          rem2;
    logic                    round_up;
    logic [QUO_W:0]          qr;
    logic [RES_W-1:0]        div_res;
    always_comb begin
        prod_ext = ACC_W'(r_prod) << (r_prod_hi ? HALF_W : 0);
        acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        rem_sh   = {r_rem, r_dvd[DIV_W-1]};
        ge       = rem_sh >= {1'b0, r_d};
        rem2     = {r_rem, 1'b0};
        round_up = rem2 >= {1'b0, r_d};
        qr       = {1'b0, r_q} + (QUO_W+1)'(round_up);
        if (!r_dneg) begin
            if (r_qovf || qr > (QUO_W+1)'(32'h7FFF_FFFF)) div_res = 32'h7FFF_FFFF;
            else                                          div_res = qr[RES_W-1:0];
        end else begin
            if (r_qovf || qr > (QUO_W+1)'(32'h8000_0000)) div_res = 32'h8000_0000;
            else                                          div_res = RES_W'(-qr[RES_W-1:0]);
        end
    end

    // multiplier, accumulator and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod     <= a_part * b_mag[B_W-1:0];
            r_prod_neg <= a_val[A_W-1] ^ b_val[B_W] ^ i_cmd.term[0];
            r_prod_hi  <= i_cmd.half;
        end
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_prod_neg ? r_acc - $signed(prod_ext) : r_acc + $signed(prod_ext);
        end
        if (i_cmd.save_d) begin
            r_d <= r_acc[DEN_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_dneg <= r_acc[ACC_W-1];
            r_dvd  <= (DIV_W'(acc_mag)) << (i_cmd.sel_icpt ? 8 : 16);
            r_rem  <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem  <= ge ? DEN_W'(rem_sh - {1'b0, r_d}) : rem_sh[DEN_W-1:0];
            r_q    <= {r_q[QUO_W-2:0], ge};
            r_qovf <= r_qovf | r_q[QUO_W-1];
        end
        if (i_cmd.div_fin) begin
            if (i_cmd.sel_icpt) r_icpt  <= div_res;
            else                r_slope <= div_res;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_slope  <= (i_cmd.emit_status == ST_OK) ? r_slope : '0;
            r_out_icpt   <= (i_cmd.emit_status == ST_OK) ? r_icpt  : '0;
        end
    end

    assign o_stat.overflowed = r_ovf;
    assign o_stat.few_points = r_count < CNT_W'(2);
    assign o_stat.degenerate = (r_d == '0) || (r_d < {1'b0, r_min});
    assign o_stat.out_busy   = r_out_valid && !i_ready;

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slope     = r_out_slope;
    assign o_intercept = r_out_icpt;

endmodule

@@ sv/lsf_controller.sv @@
// lsf_controller: state machine that sequences accumulation, products, divides and output
// depends on lsf_pkg; commands lsf_datapath
module lsf_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_point,
    output logic           o_ready,
    input  lsf_pkg::t_stat i_stat,
    output lsf_pkg::t_cmd  o_cmd
);
    import lsf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_ACC    = 4'd3;
    localparam logic [3:0] S_SAVE   = 4'd4;
    localparam logic [3:0] S_TEST   = 4'd5;
    localparam logic [3:0] S_DIVLD  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DIVFIN = 4'd8;
    localparam logic [3:0] S_WRITE  = 4'd9;

    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_W - 1);

    logic [3:0]        r_state, n_state;
    logic [TERM_W-1:0] r_term, n_term;
    logic              r_half, n_half;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [STAT_W-1:0] r_code, n_code;

    logic fire;
    assign o_ready = (r_state == S_IDLE);
    assign fire    = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_half  = r_half;
        n_dcnt  = r_dcnt;
        n_code  = r_code;
        o_cmd             = '0;
        o_cmd.term        = r_term;
        o_cmd.half        = r_half;
        o_cmd.sel_icpt    = r_term[1];
        o_cmd.emit_status = r_code;
        case (r_state)
            S_IDLE: begin
                o_cmd.accum = fire;
                if (fire && i_last_point) n_state = S_START;
            end
            S_START: begin
                if (i_stat.overflowed) begin
                    n_code  = ST_TOO_MANY;
                    n_state = S_WRITE;
                end else if (i_stat.few_points) begin
                    n_code  = ST_FEW;
                    n_state = S_WRITE;
                end else begin
                    o_cmd.clr_acc = 1'b1;
                    n_term  = TERM_N_SXX;
                    n_half  = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (!r_half) begin
                    n_half  = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_half = 1'b0;
                    n_term = r_term + TERM_W'(1);
                    if (!r_term[0])                  n_state = S_MUL;
                    else if (r_term == TERM_SX_SX)   n_state = S_SAVE;
                    else                             n_state = S_DIVLD;
                end
            end
            S_SAVE: begin
                o_cmd.save_d = 1'b1;
                n_state      = S_TEST;
            end
            S_TEST: begin
                if (i_stat.degenerate) begin
                    n_code  = ST_DEGEN;
                    n_state = S_WRITE;
                end else begin
                    o_cmd.clr_acc = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_LAST) n_state = S_DIVFIN;
            end
            S_DIVFIN: begin
                o_cmd.div_fin = 1'b1;
                if (r_term == TERM_DONE) begin
                    n_code  = ST_OK;
                    n_state = S_WRITE;
                end else begin
                    o_cmd.clr_acc = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_WRITE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.clr_run = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= TERM_N_SXX;
            r_half  <= 1'b0;
            r_dcnt  <= '0;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_half  <= n_half;
            r_dcnt  <= n_dcnt;
            r_code  <= n_code;
        end
    end

endmodule

@@ sv/least_squares_line_fit_top.sv @@
// least-squares line fit: points that are not last are taken one per cycle while no fit runs
// the last point of a run starts a fit: products on the shared 24x32 multiplier,
// two bit-serial divides and control steps
// the next run may start once the fit result is loaded into the output register
// synchronous active-low reset clears the sums, the count, the controller and
// the output valid, and sets min_denominator to 1
module least_squares_line_fit_top #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [lsf_pkg::XY_W-1:0] i_x_value,
    input  logic signed [lsf_pkg::XY_W-1:0] i_y_value,
    input  logic                          i_last_point,
    input  logic                          i_cfg_we,
    input  logic [lsf_pkg::MIN_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lsf_pkg::STAT_W-1:0]    o_status,
    output logic signed [lsf_pkg::RES_W-1:0] o_slope,
    output logic signed [lsf_pkg::RES_W-1:0] o_intercept
);
    import lsf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    lsf_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_point (i_last_point),
        .o_ready      (o_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // arithmetic and result storage
    lsf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_slope     (o_slope),
        .o_intercept (o_intercept)
    );

endmodule
